FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the header parser.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("efx checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define EFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("efx checker: next-cycle property failed");

`endif

FILE: rtl/efx_pkg.sv
// Package of the Ethernet/IPv4 five-tuple extractor: constants, status codes and
// the frame record type passed from the capture front end to the status back end.
// Depends on nothing.
package efx_pkg;

    // Width of the captured byte counter; it saturates at all ones.
    localparam int unsigned LEN_BITS = 16;
    localparam logic [LEN_BITS-1:0] COUNT_MAX = {LEN_BITS{1'b1}};

    // Byte positions and sizes of the headers.
    localparam int unsigned ETH_HDR_BYTES = 14;
    localparam int unsigned MAC_BYTES     = 6;
    localparam int unsigned PROTO_POS     = 23;
    localparam int unsigned SRC_IP_POS    = 26;
    localparam int unsigned DST_IP_POS    = 30;
    localparam int unsigned IP_ADDR_BYTES = 4;
    localparam int unsigned IP_MIN_BYTES  = 20;
    localparam int unsigned L4_MIN_BYTES  = 8;
    localparam int unsigned PORT_BYTES    = 4;

    // Protocol numbers that carry ports.
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Status codes of a record.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT_ETH = 3'd1;
    localparam logic [2:0] ST_SHORT_IP  = 3'd2;
    localparam logic [2:0] ST_SHORT_OPT = 3'd3;
    localparam logic [2:0] ST_SHORT_L4  = 3'd4;

    // Record queue between the front and back ends (a power of two).
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Fields of one finished frame as the front end captured them.
    typedef struct packed {
        logic [31:0]         src_ip;
        logic [31:0]         dst_ip;
        logic [7:0]          protocol;
        logic [15:0]         src_port;
        logic [15:0]         dst_port;
        logic [47:0]         dst_mac;
        logic [47:0]         src_mac;
        logic [LEN_BITS-1:0] len;
        logic [3:0]          hdr_words;
    } efx_rec_t;

    // Result fields held in the output register.
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] frame_length;
        logic [2:0]  status;
    } efx_out_t;

    // Saturate the byte count to the 16-bit length field.
    function automatic logic [15:0] sat_len(input logic [LEN_BITS-1:0] len);
        logic [32:0] wide;
        wide = 33'(len);
        if (wide > 33'h0_0000_FFFF)
            return 16'hFFFF;
        return wide[15:0];
    endfunction

endpackage

FILE: rtl/efx_stream_if.sv
// Valid/ready channel interfaces of the five-tuple extractor: the byte stream in
// and the record stream out. Depends on nothing.

// Frame bytes, one per item, with a mark on the final byte.
interface efx_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// One parsed header record per frame.
interface efx_record_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] frame_length;
    logic [2:0]  status;

    modport source (output valid, output src_ip, output dst_ip, output protocol,
                    output src_port, output dst_port, output dst_mac, output src_mac,
                    output frame_length, output status, input ready);
    modport sink   (input valid, input src_ip, input dst_ip, input protocol,
                    input src_port, input dst_port, input dst_mac, input src_mac,
                    input frame_length, input status, output ready);
endinterface

FILE: rtl/ipv4_five_tuple_extractor.sv
// Ethernet/IPv4/TCP-UDP header parser.
// frame (sink): one captured frame byte per item in wire order; last_byte marks
//   the final byte. record (source): one item per frame with both MAC addresses,
//   the IPv4 addresses and protocol, the TCP/UDP ports (zero for other protocols
//   or when missing), the captured length (saturating) and a truncation status.
// Throughput: one byte per cycle unless the record queue is full, sustained
//   across frame boundaries, so records can be produced as often as once per
//   cycle (one-byte frames). The edge that takes the last byte writes the record
//   queue; the record then loads the output register when it is free or emptied.
// Stalls: the output register and a two-entry record queue decouple the sides.
//   Bytes keep flowing while records wait; frame.ready falls only when the
//   queue is full, which needs at least two records stalled behind the output.
// Reset: rst_n clears the byte counter, all captured fields, the queue and the
//   output valid flag; the first byte after reset starts a new frame.
module ipv4_five_tuple_extractor (
    input  logic         clk,
    input  logic         rst_n,
    efx_frame_if.sink    frame,
    efx_record_if.source record
);

    logic              push_valid;
    logic              push_ready;
    efx_pkg::efx_rec_t push_rec;
    logic              head_valid;
    logic              head_ready;
    efx_pkg::efx_rec_t head_rec;

    // Byte capture.
    efx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    // Record queue.
    efx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_rec    (head_rec)
    );

    // Status and output register.
    efx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head_rec   (head_rec),
        .record     (record)
    );

endmodule

FILE: rtl/efx_front.sv
// Capture front end: counts frame bytes and captures header fields by position.
// Depends on efx_pkg and efx_frame_if; pushes one efx_rec_t per frame.
module efx_front (
    input  logic              clk,
    input  logic              rst_n,
    efx_frame_if.sink         frame,
    output logic              push_valid,
    input  logic              push_ready,
    output efx_pkg::efx_rec_t push_rec
);

    localparam int unsigned LB = efx_pkg::LEN_BITS;

    logic [LB-1:0] cnt_reg,      cnt_next;
    logic [3:0]    hw_reg,       hw_next;
    logic [7:0]    proto_reg,    proto_next;
    logic [31:0]   src_ip_reg,   src_ip_next;
    logic [31:0]   dst_ip_reg,   dst_ip_next;
    logic [47:0]   dst_mac_reg,  dst_mac_next;
    logic [47:0]   src_mac_reg,  src_mac_next;
    logic [15:0]   src_port_reg, src_port_next;
    logic [15:0]   dst_port_reg, dst_port_next;

    logic [LB-1:0] pos;
    logic [7:0]    b;
    logic [3:0]    hw_eff;
    logic [6:0]    pbase;
    logic [LB-1:0] poff;
    logic [LB-1:0] mac_off;
    logic [LB-1:0] ip_off;
    logic          port_hit;
    logic          fire;

    // The front end takes a byte whenever the queue can take a record.
    assign frame.ready = push_ready;
    assign fire        = frame.valid && frame.ready;

    // Field capture for the byte at the current position.
    always_comb
    begin
        pos = cnt_reg;
        b   = frame.data_byte;

        hw_next       = hw_reg;
        proto_next    = proto_reg;
        src_ip_next   = src_ip_reg;
        dst_ip_next   = dst_ip_reg;
        dst_mac_next  = dst_mac_reg;
        src_mac_next  = src_mac_reg;
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;

        // The header length is live on the very byte that carries it.
        hw_eff   = (pos == LB'(efx_pkg::ETH_HDR_BYTES)) ? b[3:0] : hw_reg;
        pbase    = 7'(efx_pkg::ETH_HDR_BYTES) + {1'b0, hw_eff, 2'b00};
        poff     = pos - LB'(pbase);
        port_hit = (pos >= LB'(pbase)) && (poff < LB'(efx_pkg::PORT_BYTES));
        mac_off  = pos - LB'(efx_pkg::MAC_BYTES);
        ip_off   = (pos >= LB'(efx_pkg::DST_IP_POS)) ? pos - LB'(efx_pkg::DST_IP_POS)
                                                     : pos - LB'(efx_pkg::SRC_IP_POS);

        // Ethernet and IPv4 fields occupy disjoint positions.
        if (pos < LB'(efx_pkg::MAC_BYTES))
        begin
            dst_mac_next[{3'(efx_pkg::MAC_BYTES - 1) - pos[2:0], 3'b000} +: 8] = b;
        end
        else if (pos < LB'(2 * efx_pkg::MAC_BYTES))
        begin
            src_mac_next[{3'(efx_pkg::MAC_BYTES - 1) - mac_off[2:0], 3'b000} +: 8] = b;
        end
        else if (pos == LB'(efx_pkg::ETH_HDR_BYTES))
        begin
            hw_next = b[3:0];
        end
        else if (pos == LB'(efx_pkg::PROTO_POS))
        begin
            proto_next = b;
        end
        else if (pos >= LB'(efx_pkg::SRC_IP_POS) && pos < LB'(efx_pkg::DST_IP_POS))
        begin
            src_ip_next[{2'(efx_pkg::IP_ADDR_BYTES - 1) - ip_off[1:0], 3'b000} +: 8] = b;
        end
        else if (pos >= LB'(efx_pkg::DST_IP_POS)
                 && pos < LB'(efx_pkg::DST_IP_POS + efx_pkg::IP_ADDR_BYTES))
        begin
            dst_ip_next[{2'(efx_pkg::IP_ADDR_BYTES - 1) - ip_off[1:0], 3'b000} +: 8] = b;
        end

        // Ports follow the IPv4 header, wherever its length puts them.
        if (port_hit)
        begin
            if (!poff[1])
                src_port_next[{~poff[0], 3'b000} +: 8] = b;
            else
                dst_port_next[{~poff[0], 3'b000} +: 8] = b;
        end

        // Saturating byte count.
        cnt_next = (cnt_reg != efx_pkg::COUNT_MAX) ? cnt_reg + LB'(1) : cnt_reg;
    end

    // The last byte's captures go straight into the record.
    always_comb
    begin
        push_valid         = fire && frame.last_byte;
        push_rec.src_ip    = src_ip_next;
        push_rec.dst_ip    = dst_ip_next;
        push_rec.protocol  = proto_next;
        push_rec.src_port  = src_port_next;
        push_rec.dst_port  = dst_port_next;
        push_rec.dst_mac   = dst_mac_next;
        push_rec.src_mac   = src_mac_next;
        push_rec.len       = cnt_next;
        push_rec.hdr_words = hw_next;
    end

    // Frame state: updated on every item, cleared after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            hw_reg       <= '0;
            proto_reg    <= '0;
            src_ip_reg   <= '0;
            dst_ip_reg   <= '0;
            dst_mac_reg  <= '0;
            src_mac_reg  <= '0;
            src_port_reg <= '0;
            dst_port_reg <= '0;
        end
        else if (fire)
        begin
            if (frame.last_byte)
            begin
                cnt_reg      <= '0;
                hw_reg       <= '0;
                proto_reg    <= '0;
                src_ip_reg   <= '0;
                dst_ip_reg   <= '0;
                dst_mac_reg  <= '0;
                src_mac_reg  <= '0;
                src_port_reg <= '0;
                dst_port_reg <= '0;
            end
            else
            begin
                cnt_reg      <= cnt_next;
                hw_reg       <= hw_next;
                proto_reg    <= proto_next;
                src_ip_reg   <= src_ip_next;
                dst_ip_reg   <= dst_ip_next;
                dst_mac_reg  <= dst_mac_next;
                src_mac_reg  <= src_mac_next;
                src_port_reg <= src_port_next;
                dst_port_reg <= dst_port_next;
            end
        end
    end

endmodule

FILE: rtl/efx_queue.sv
// Short record queue between the capture front end and the status back end.
// Depends on efx_pkg (efx_rec_t, QUEUE_DEPTH).
module efx_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  efx_pkg::efx_rec_t push_rec,
    output logic              pop_valid,
    input  logic              pop_ready,
    output efx_pkg::efx_rec_t pop_rec
);

    localparam int unsigned PB = efx_pkg::QPTR_BITS;

    efx_pkg::efx_rec_t mem [efx_pkg::QUEUE_DEPTH];
    logic [PB-1:0]     wr_ptr_reg;
    logic [PB-1:0]     rd_ptr_reg;
    logic [PB:0]       count_reg;
    logic              do_push;
    logic              do_pop;

    // Handshake on both sides.
    assign push_ready = (count_reg != (PB + 1)'(efx_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_rec    = mem[rd_ptr_reg];

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_rec;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PB'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PB'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (PB + 1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (PB + 1)'(1);
        end
    end

endmodule

FILE: rtl/efx_back.sv
// Status back end: classifies truncation, gates the ports and holds the result
// in the output register. Depends on efx_pkg and efx_record_if.
module efx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    output logic              head_ready,
    input  efx_pkg::efx_rec_t head_rec,
    efx_record_if.source      record
);

    localparam int unsigned LB = efx_pkg::LEN_BITS;

    logic              valid_reg;
    efx_pkg::efx_out_t out_reg;
    efx_pkg::efx_out_t out_next;
    logic [LB-1:0]     rem;
    logic [LB-1:0]     hw_bytes;
    logic [2:0]        st;
    logic              has_ports;

    // Take the next record when the output register is free or being emptied.
    assign head_ready = !valid_reg || record.ready;

    // Truncation status and port gating.
    always_comb
    begin
        rem      = head_rec.len - LB'(efx_pkg::ETH_HDR_BYTES);
        hw_bytes = LB'({head_rec.hdr_words, 2'b00});

        if (head_rec.len < LB'(efx_pkg::ETH_HDR_BYTES))
            st = efx_pkg::ST_SHORT_ETH;
        else if (rem < LB'(efx_pkg::IP_MIN_BYTES))
            st = efx_pkg::ST_SHORT_IP;
        else if (rem < hw_bytes)
            st = efx_pkg::ST_SHORT_OPT;
        else if (rem < hw_bytes + LB'(efx_pkg::L4_MIN_BYTES))
            st = efx_pkg::ST_SHORT_L4;
        else
            st = efx_pkg::ST_OK;

        has_ports = (head_rec.protocol == efx_pkg::PROTO_TCP
                     || head_rec.protocol == efx_pkg::PROTO_UDP)
                    && (st == efx_pkg::ST_OK || st == efx_pkg::ST_SHORT_L4);

        out_next.src_ip       = head_rec.src_ip;
        out_next.dst_ip       = head_rec.dst_ip;
        out_next.protocol     = head_rec.protocol;
        out_next.src_port     = has_ports ? head_rec.src_port : 16'h0000;
        out_next.dst_port     = has_ports ? head_rec.dst_port : 16'h0000;
        out_next.dst_mac      = head_rec.dst_mac;
        out_next.src_mac      = head_rec.src_mac;
        out_next.frame_length = efx_pkg::sat_len(head_rec.len);
        out_next.status       = st;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (head_ready)
            valid_reg <= head_valid;
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (head_valid && head_ready)
            out_reg <= out_next;
    end

    // Drive the record channel.
    assign record.valid        = valid_reg;
    assign record.src_ip       = out_reg.src_ip;
    assign record.dst_ip       = out_reg.dst_ip;
    assign record.protocol     = out_reg.protocol;
    assign record.src_port     = out_reg.src_port;
    assign record.dst_port     = out_reg.dst_port;
    assign record.dst_mac      = out_reg.dst_mac;
    assign record.src_mac      = out_reg.src_mac;
    assign record.frame_length = out_reg.frame_length;
    assign record.status       = out_reg.status;

endmodule

FILE: rtl/efx_checker.sv
// Port-level checker for the five-tuple extractor, bound to the top level.
// Depends on assert_macros.svh and efx_pkg.
`include "assert_macros.svh"

module efx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_src_ip,
    input logic [7:0]  out_protocol,
    input logic [15:0] out_src_port,
    input logic [15:0] out_dst_port,
    input logic [15:0] out_frame_length,
    input logic [2:0]  out_status
);

    logic        out_stall;
    logic        out_no_ports;
    logic [50:0] out_seen;

    // Shorthands for the properties below.
    assign out_stall    = out_valid && !out_ready;
    assign out_no_ports = out_protocol != efx_pkg::PROTO_TCP
                          && out_protocol != efx_pkg::PROTO_UDP;
    assign out_seen     = {out_src_ip, out_frame_length, out_status};

    // A stalled record stays offered.
    `EFX_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_stall, out_valid)

    // A stalled record keeps its source address, length and status.
    `EFX_ASSERT_NEXT(a_hold_data, clk, rst_n, out_stall, $stable(out_seen))

    // A short Ethernet status only comes with fewer bytes than the Ethernet header.
    `EFX_ASSERT_IMPL(a_short_eth_len, clk, rst_n, out_valid && out_status == efx_pkg::ST_SHORT_ETH, out_frame_length < 16'(efx_pkg::ETH_HDR_BYTES))

    // Ports are only reported for TCP and UDP.
    `EFX_ASSERT_IMPL(a_ports_gated, clk, rst_n, out_valid && out_no_ports, out_src_port == 16'h0000 && out_dst_port == 16'h0000)

endmodule

bind ipv4_five_tuple_extractor efx_checker u_efx_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (record.valid),
    .out_ready        (record.ready),
    .out_src_ip       (record.src_ip),
    .out_protocol     (record.protocol),
    .out_src_port     (record.src_port),
    .out_dst_port     (record.dst_port),
    .out_frame_length (record.frame_length),
    .out_status       (record.status)
);
